/* src/lpc_pkg.sv */
// Package for the lift position controller.
// Holds the state encoding, register indexes, reset values and item types.
// No dependencies.
package lpc_pkg;

    // Configuration registers are all 20 bits wide.
    localparam int CFG_W       = 20;
    localparam int CFG_IDX_W   = 2;
    localparam int TIMER_W_DEF = 20;
    localparam int CODE_W      = 4;

    // Register reset values, in ticks.
    localparam logic [CFG_W-1:0] PREP_TIMEOUT_RST = 20'd10000;
    localparam logic [CFG_W-1:0] REST_LIMIT_RST   = 20'd60000;
    localparam logic [CFG_W-1:0] WAKE_DELAY_RST   = 20'd100;
    localparam logic [CFG_W-1:0] MOVE_TIMEOUT_RST = 20'd1000;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PREP_TIMEOUT = 2'd0,
        CFG_REST_LIMIT   = 2'd1,
        CFG_WAKE_DELAY   = 2'd2,
        CFG_MOVE_TIMEOUT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] prep_timeout;
        logic [CFG_W-1:0] rest_limit;
        logic [CFG_W-1:0] wake_delay;
        logic [CFG_W-1:0] move_timeout;
    } t_cfg;

    // Controller states, one-hot.
    typedef enum logic [12:0] {
        ST_INIT      = 13'b0000000000001,
        ST_PREP      = 13'b0000000000010,
        ST_UP        = 13'b0000000000100,
        ST_UP_ON     = 13'b0000000001000,
        ST_DOWN      = 13'b0000000010000,
        ST_MID       = 13'b0000000100000,
        ST_PRE_DOWN  = 13'b0000001000000,
        ST_MOVE_DOWN = 13'b0000010000000,
        ST_MOVE_UP   = 13'b0000100000000,
        ST_STOP      = 13'b0001000000000,
        ST_IDLE      = 13'b0010000000000,
        ST_RESUME    = 13'b0100000000000,
        ST_DEAD      = 13'b1000000000000
    } t_state;

    // External state codes as reported on the result channel.
    localparam logic [CODE_W-1:0] CODE_INIT      = 4'd0;
    localparam logic [CODE_W-1:0] CODE_PREP      = 4'd1;
    localparam logic [CODE_W-1:0] CODE_UP        = 4'd2;
    localparam logic [CODE_W-1:0] CODE_UP_ON     = 4'd3;
    localparam logic [CODE_W-1:0] CODE_DOWN      = 4'd4;
    localparam logic [CODE_W-1:0] CODE_MID       = 4'd5;
    localparam logic [CODE_W-1:0] CODE_PRE_DOWN  = 4'd6;
    localparam logic [CODE_W-1:0] CODE_MOVE_DOWN = 4'd7;
    localparam logic [CODE_W-1:0] CODE_MOVE_UP   = 4'd8;
    localparam logic [CODE_W-1:0] CODE_STOP      = 4'd9;
    localparam logic [CODE_W-1:0] CODE_IDLE      = 4'd10;
    localparam logic [CODE_W-1:0] CODE_RESUME    = 4'd11;
    localparam logic [CODE_W-1:0] CODE_DEAD      = 4'd12;

    // Decoded lift position.
    typedef enum logic [1:0] {
        POS_UP      = 2'd0,
        POS_DOWN    = 2'd1,
        POS_MID     = 2'd2,
        POS_UNKNOWN = 2'd3
    } t_pos;

    // Flags that live alongside the state register.
    typedef struct packed {
        logic last_dir_up;
        logic held_button;
        logic supply_on;
    } t_flags;

    typedef struct packed {
        logic limit_up_n;
        logic limit_down_n;
        logic load_on;
        logic button_pulse;
    } t_item;

    typedef struct packed {
        logic [CODE_W-1:0] state_code;
        logic              state_entered;
        logic              pulse_up;
        logic              pulse_down;
        logic              pulse_stop;
        logic              supply_level;
    } t_result;

    // Map a one-hot state to its external code.
    function automatic logic [CODE_W-1:0] state_to_code(input t_state st);
        logic [CODE_W-1:0] code;
        code = CODE_INIT;
        case (st)
            ST_PREP:      code = CODE_PREP;
            ST_UP:        code = CODE_UP;
            ST_UP_ON:     code = CODE_UP_ON;
            ST_DOWN:      code = CODE_DOWN;
            ST_MID:       code = CODE_MID;
            ST_PRE_DOWN:  code = CODE_PRE_DOWN;
            ST_MOVE_DOWN: code = CODE_MOVE_DOWN;
            ST_MOVE_UP:   code = CODE_MOVE_UP;
            ST_STOP:      code = CODE_STOP;
            ST_IDLE:      code = CODE_IDLE;
            ST_RESUME:    code = CODE_RESUME;
            ST_DEAD:      code = CODE_DEAD;
            default:      code = CODE_INIT;
        endcase
        return code;
    endfunction

endpackage

/* src/lpc_if.sv */
// Valid/ready channel interfaces for the lift position controller.
// One interface for tick items, one for result items. No dependencies.
interface lpc_item_if;
    logic valid;
    logic ready;
    logic limit_up_n;
    logic limit_down_n;
    logic load_on;
    logic button_pulse;

    modport source (output valid, output limit_up_n, output limit_down_n,
                    output load_on, output button_pulse, input ready);
    modport sink   (input valid, input limit_up_n, input limit_down_n,
                    input load_on, input button_pulse, output ready);
endinterface

interface lpc_result_if;
    logic       valid;
    logic       ready;
    logic [3:0] state_code;
    logic       state_entered;
    logic       pulse_up;
    logic       pulse_down;
    logic       pulse_stop;
    logic       supply_level;

    modport source (output valid, output state_code, output state_entered,
                    output pulse_up, output pulse_down, output pulse_stop,
                    output supply_level, input ready);
    modport sink   (input valid, input state_code, input state_entered,
                    input pulse_up, input pulse_down, input pulse_stop,
                    input supply_level, output ready);
endinterface

/* src/lpc_cfg.sv */
// Configuration register bank of the lift position controller.
// Depends on lpc_pkg.
module lpc_cfg
    import lpc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    // Timeout registers, written one at a time by index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prep_timeout <= PREP_TIMEOUT_RST;
            r_cfg.rest_limit   <= REST_LIMIT_RST;
            r_cfg.wake_delay   <= WAKE_DELAY_RST;
            r_cfg.move_timeout <= MOVE_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PREP_TIMEOUT: r_cfg.prep_timeout <= i_cfg_data;
                CFG_REST_LIMIT:   r_cfg.rest_limit   <= i_cfg_data;
                CFG_WAKE_DELAY:   r_cfg.wake_delay   <= i_cfg_data;
                CFG_MOVE_TIMEOUT: r_cfg.move_timeout <= i_cfg_data;
                default:          r_cfg.move_timeout <= r_cfg.move_timeout;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* src/lpc_step.sv */
// Next-state logic of the lift position controller for one tick item.
// Decodes position, runs the tick counter and timeouts, forms the result.
// Depends on lpc_pkg.
module lpc_step
    import lpc_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_W_DEF
) (
    input  t_state                 i_state,
    input  logic [TIMER_WIDTH-1:0] i_elapsed,
    input  t_flags                 i_flags,
    input  t_cfg                   i_cfg,
    input  t_item                  i_item,
    output t_state                 o_state,
    output logic [TIMER_WIDTH-1:0] o_elapsed,
    output t_flags                 o_flags,
    output t_result                o_result
);

    localparam int CMP_W = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;
    localparam logic [TIMER_WIDTH-1:0] TMR_MAX = {TIMER_WIDTH{1'b1}};

    t_pos                   pos;
    logic                   press;
    logic                   load;
    logic [TIMER_WIDTH-1:0] tick;
    logic [CMP_W-1:0]       tick_x;
    logic                   prep_to;
    logic                   idle_to;
    logic                   resume_to;
    logic                   move_to;
    t_state                 nxt;
    logic                   reenter;
    logic                   held_n;
    logic                   entered;
    logic                   supply_n;
    logic                   dir_n;
    logic                   pu;
    logic                   pd;
    logic                   ps;

    // Position is only trusted while the supply is on and the switches agree.
    always_comb begin
        if (!i_flags.supply_on) begin
            pos = POS_UNKNOWN;
        end else if (!i_item.limit_up_n && i_item.limit_down_n) begin
            pos = POS_UP;
        end else if (i_item.limit_up_n && !i_item.limit_down_n) begin
            pos = POS_DOWN;
        end else if (i_item.limit_up_n && i_item.limit_down_n) begin
            pos = POS_MID;
        end else begin
            pos = POS_UNKNOWN;
        end
    end

    assign load  = i_item.load_on;
    assign press = i_item.button_pulse | i_flags.held_button;

    // Saturating tick counter and timeout compares.
    assign tick      = (i_elapsed == TMR_MAX) ? i_elapsed : i_elapsed + 1'b1;
    assign tick_x    = CMP_W'(tick);
    assign prep_to   = tick_x >= CMP_W'(i_cfg.prep_timeout);
    assign idle_to   = tick_x >= CMP_W'(i_cfg.rest_limit);
    assign resume_to = tick_x >= CMP_W'(i_cfg.wake_delay);
    assign move_to   = tick_x >= CMP_W'(i_cfg.move_timeout);

    // State transitions and held button request.
    always_comb begin
        nxt     = i_state;
        reenter = 1'b0;
        held_n  = 1'b0;
        case (i_state)
            ST_PREP: begin
                held_n = i_flags.held_button;
                if (pos == POS_UP)        nxt = ST_UP;
                else if (pos == POS_DOWN) nxt = ST_DOWN;
                else if (pos == POS_MID)  nxt = ST_MID;
                else if (prep_to)         nxt = ST_DEAD;
            end
            ST_UP: begin
                if (load)                                    nxt = ST_UP_ON;
                else if (press)                              nxt = ST_MOVE_DOWN;
                else if (pos == POS_DOWN || pos == POS_MID)  nxt = ST_PREP;
                else if (idle_to)                            nxt = ST_IDLE;
            end
            ST_UP_ON: begin
                if (!load)                                   nxt = ST_PRE_DOWN;
                else if (pos == POS_DOWN || pos == POS_MID)  nxt = ST_PREP;
            end
            ST_PRE_DOWN: begin
                if (load)                                    nxt = ST_UP_ON;
                else if (press)                              nxt = ST_MOVE_DOWN;
                else if (pos == POS_DOWN || pos == POS_MID)  nxt = ST_PREP;
            end
            ST_MOVE_DOWN: begin
                if (load)                 nxt = ST_MOVE_UP;
                else if (press)           nxt = ST_STOP;
                else if (pos == POS_DOWN) nxt = ST_DOWN;
                else if (move_to)         reenter = 1'b1;
            end
            ST_DOWN: begin
                if (load || press)                         nxt = ST_MOVE_UP;
                else if (pos == POS_UP || pos == POS_MID)  nxt = ST_PREP;
                else if (idle_to)                          nxt = ST_IDLE;
            end
            ST_IDLE: begin
                held_n = press;
                if (press || load) nxt = ST_RESUME;
            end
            ST_RESUME: begin
                held_n = i_flags.held_button;
                if (resume_to) nxt = ST_PREP;
            end
            ST_MOVE_UP: begin
                if (pos == POS_UP)  nxt = ST_UP;
                else if (press)     nxt = ST_STOP;
                else if (move_to)   reenter = 1'b1;
            end
            ST_MID: begin
                if (load)        nxt = ST_MOVE_UP;
                else if (press)  nxt = i_flags.last_dir_up ? ST_MOVE_DOWN : ST_MOVE_UP;
                else if (pos == POS_UP || pos == POS_DOWN) nxt = ST_PREP;
                else if (idle_to) nxt = ST_IDLE;
            end
            ST_STOP: begin
                held_n = i_flags.held_button;
                nxt    = ST_PREP;
            end
            ST_DEAD: begin
                if (press) nxt = ST_PREP;
            end
            default: begin
                // Init and any unexpected encoding go straight to preparation.
                held_n = i_flags.held_button;
                nxt    = ST_PREP;
            end
        endcase
    end

    // Entry actions: restart the counter, pulse the motor, switch the supply.
    always_comb begin
        entered  = (nxt != i_state) || reenter;
        supply_n = i_flags.supply_on;
        dir_n    = i_flags.last_dir_up;
        pu       = 1'b0;
        pd       = 1'b0;
        ps       = 1'b0;
        if (entered) begin
            case (nxt)
                ST_PREP, ST_RESUME: supply_n = 1'b1;
                ST_IDLE, ST_DEAD:   supply_n = 1'b0;
                ST_MOVE_DOWN: begin
                    pd    = 1'b1;
                    dir_n = 1'b0;
                end
                ST_MOVE_UP: begin
                    pu    = 1'b1;
                    dir_n = 1'b1;
                end
                ST_STOP:            ps = 1'b1;
                default:            supply_n = i_flags.supply_on;
            endcase
        end
    end

    assign o_state             = nxt;
    assign o_elapsed           = entered ? '0 : tick;
    assign o_flags.last_dir_up = dir_n;
    assign o_flags.held_button = held_n;
    assign o_flags.supply_on   = supply_n;

    assign o_result.state_code    = state_to_code(nxt);
    assign o_result.state_entered = entered;
    assign o_result.pulse_up      = pu;
    assign o_result.pulse_down    = pd;
    assign o_result.pulse_stop    = ps;
    assign o_result.supply_level  = supply_n;

endmodule

/* src/lift_position_controller.sv */
// Top level of the lift position controller: tick register, controller state
// and result register. Depends on lpc_pkg, lpc_if, lpc_cfg and lpc_step.
//
// Usage:
// The tick channel takes one item per millisecond tick with the two active-low
// limit switches, the qualified load level and a button pulse. The result
// channel gives exactly one item per tick: the state code after the tick, an
// entry flag, one-shot up, down and stop motor pulses and the supply level.
// Timeouts are set through the write port (index 0 prep, 1 idle, 2 resume,
// 3 move); the user must do so only while no tick is in flight, as the block
// itself does not enforce it. An item taken goes into the tick register, is
// processed from there and its result is loaded into the result register.
// Throughput is one item per cycle while the receiver does not stall; the
// controller state register updates in the same cycle the result is loaded,
// so the next tick sees it. When the receiver stalls, the result register
// holds and the tick register still takes one more item; after that ready
// drops until the result moves. Reset clears both stages, the state to init,
// the counter, the flags and the timeouts to their defaults.
module lift_position_controller
    import lpc_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_W_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    lpc_item_if.sink             i_in,
    lpc_result_if.source         o_out
);

    t_cfg                   cfg;
    logic                   r_in_valid;
    t_item                  r_in;
    logic                   r_out_valid;
    t_result                r_out;
    t_state                 r_state;
    logic [TIMER_WIDTH-1:0] r_elapsed;
    t_flags                 r_flags;
    t_state                 n_state;
    logic [TIMER_WIDTH-1:0] n_elapsed;
    t_flags                 n_flags;
    t_result                n_out;
    logic                   advance;

    lpc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    lpc_step #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_step (
        .i_state   (r_state),
        .i_elapsed (r_elapsed),
        .i_flags   (r_flags),
        .i_cfg     (cfg),
        .i_item    (r_in),
        .o_state   (n_state),
        .o_elapsed (n_elapsed),
        .o_flags   (n_flags),
        .o_result  (n_out)
    );

    // A tick moves to the result register when that register is free.
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    // Stage valids and controller state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= ST_INIT;
            r_elapsed   <= '0;
            r_flags     <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
                r_elapsed   <= n_elapsed;
                r_flags     <= n_flags;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.limit_up_n   <= i_in.limit_up_n;
            r_in.limit_down_n <= i_in.limit_down_n;
            r_in.load_on      <= i_in.load_on;
            r_in.button_pulse <= i_in.button_pulse;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.state_code    = r_out.state_code;
    assign o_out.state_entered = r_out.state_entered;
    assign o_out.pulse_up      = r_out.pulse_up;
    assign o_out.pulse_down    = r_out.pulse_down;
    assign o_out.pulse_stop    = r_out.pulse_stop;
    assign o_out.supply_level  = r_out.supply_level;

    // At most one motor pulse per result.
    a_one_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $onehot0({r_out.pulse_up, r_out.pulse_down, r_out.pulse_stop}))
        else $error("more than one motor pulse in one result");

    // A motor pulse only comes with a state entry.
    a_pulse_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.pulse_up || r_out.pulse_down || r_out.pulse_stop))
        |-> r_out.state_entered)
        else $error("motor pulse without state entry");

    // The raise pulse always goes with the move-up state.
    a_pulse_up_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.pulse_up) |-> (r_out.state_code == CODE_MOVE_UP))
        else $error("raise pulse outside move-up state");

    // With the supply off the lift can only be in init, idle or dead.
    a_supply_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.supply_level) |->
        (r_out.state_code == CODE_INIT || r_out.state_code == CODE_IDLE ||
         r_out.state_code == CODE_DEAD))
        else $error("supply off in a powered state");

endmodule
